// ----- rtl/tgs_pkg.sv -----
package tgs_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_PHASE_STEP = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MOD_DEPTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_GAIN       = 2'd2;

    // Register widths and reset values.
    localparam int STEP_W  = 23;
    localparam int DEPTH_W = 16;
    localparam int GAIN_W  = 16;

    localparam logic [STEP_W-1:0]  PHASE_STEP_RST = 23'd89478;
    localparam logic [DEPTH_W-1:0] MOD_DEPTH_RST  = 16'd0;
    localparam logic [GAIN_W-1:0]  GAIN_RST       = 16'd4096;

    // Odd sine polynomial coefficients in Q30.
    localparam int POLY_W = 31;
    localparam logic [POLY_W-1:0] POLY_C1 = 31'd1686629713;
    localparam logic [POLY_W-1:0] POLY_C3 = 31'd693598670;
    localparam logic [POLY_W-1:0] POLY_C5 = 31'd85569278;
    localparam logic [POLY_W-1:0] POLY_C7 = 31'd5026992;

    // Quarter-wave argument (Q16, 0..65536) and the shared multiplier product.
    localparam int ARG_W  = 17;
    localparam int PROD_W = POLY_W + ARG_W;

    // Modulation factor in Q1.15 (signed, 18 bits holds -32766..98301) and
    // the factor times the Q4.12 gain.
    localparam int FACT_W = 18;
    localparam int GF_W   = FACT_W + GAIN_W + 1;
    localparam logic signed [FACT_W-1:0] FACT_ONE = 18'sd32768;

    // Q1.15 times Q4.12 leaves 27 fraction bits to drop.
    localparam int OUT_SHIFT = 27;

endpackage

// ----- rtl/tremolo_gain_stage.sv -----
// Frames are processed one at a time: a new input frame is accepted only once the
// previous result has been loaded into the output register. The LFO sequencer runs
// seven steps (sine polynomial, depth and gain); the polynomial steps share one multiplier.
// A finished frame waits in the output register while the next is computed.
// Reset (i_rst_n low at a clock edge) clears the LFO phase and output valid and
// returns phase_step, mod_depth and gain to 89478, 0 and unity.
module tremolo_gain_stage #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS      = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // Input frame: left_sample, right_sample.
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
    // Output frame: left_out, right_out.
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        m_axis_tdata,
    // Output flag: clipped.
    output logic                                      m_axis_tuser,
    input  logic                                      i_cfg_we,
    input  logic [tgs_pkg::CFG_ADDR_W-1:0]            i_cfg_addr,
    input  logic [tgs_pkg::CFG_DATA_W-1:0]            i_cfg_wdata
);

    localparam int TDATA_W = ((2*SAMPLE_BITS+7)/8)*8;

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_LFO  = 4'b0010,
        T_MUL  = 4'b0100,
        T_OUT  = 4'b1000
    } t_top_state;

    t_top_state r_state, n_state;
    logic [tgs_pkg::STEP_W-1:0]         r_phase_step;
    logic [tgs_pkg::DEPTH_W-1:0]        r_mod_depth;
    logic [tgs_pkg::GAIN_W-1:0]         r_gain;
    logic signed [SAMPLE_BITS-1:0]      r_left_in;
    logic signed [SAMPLE_BITS-1:0]      r_right_in;
    logic [SAMPLE_BITS-1:0]             r_left_out;
    logic [SAMPLE_BITS-1:0]             r_right_out;
    logic                               r_clip;
    logic                               r_out_valid;

    logic                               in_xfer;
    logic                               out_load;
    logic                               lfo_done;
    logic signed [tgs_pkg::GF_W-1:0]    gain_factor;
    logic [SAMPLE_BITS-1:0]             left_res;
    logic [SAMPLE_BITS-1:0]             right_res;
    logic                               left_clip;
    logic                               right_clip;

    assign s_axis_tready = (r_state == T_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == T_OUT) && (!r_out_valid || m_axis_tready);

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= tgs_pkg::PHASE_STEP_RST;
            r_mod_depth  <= tgs_pkg::MOD_DEPTH_RST;
            r_gain       <= tgs_pkg::GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tgs_pkg::CFG_IDX_PHASE_STEP: r_phase_step <= i_cfg_wdata;
                tgs_pkg::CFG_IDX_MOD_DEPTH:  r_mod_depth  <= i_cfg_wdata[tgs_pkg::DEPTH_W-1:0];
                tgs_pkg::CFG_IDX_GAIN:       r_gain       <= i_cfg_wdata[tgs_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Frame sequencing.
    always_comb begin
        unique case (r_state)
            T_IDLE:  n_state = in_xfer ? T_LFO : T_IDLE;
            T_LFO:   n_state = lfo_done ? T_MUL : T_LFO;
            T_MUL:   n_state = T_OUT;
            T_OUT:   n_state = out_load ? T_IDLE : T_OUT;
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= out_load || (r_out_valid && !m_axis_tready);
        end
    end

    // Input frame capture.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_left_in  <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_right_in <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
    end

    tgs_lfo #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_lfo (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (in_xfer),
        .i_phase_step  (r_phase_step),
        .i_mod_depth   (r_mod_depth),
        .i_gain        (r_gain),
        .o_done        (lfo_done),
        .o_gain_factor (gain_factor)
    );

    // One lane per channel, both loaded when the factor is ready.
    tgs_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_left (
        .i_clk         (i_clk),
        .i_load        (lfo_done),
        .i_sample      (r_left_in),
        .i_gain_factor (gain_factor),
        .o_sample      (left_res),
        .o_clip        (left_clip)
    );

    tgs_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_right (
        .i_clk         (i_clk),
        .i_load        (lfo_done),
        .i_sample      (r_right_in),
        .i_gain_factor (gain_factor),
        .o_sample      (right_res),
        .o_clip        (right_clip)
    );

    // Merge the lanes into the output register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_left_out  <= left_res;
            r_right_out <= right_res;
            r_clip      <= left_clip || right_clip;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'({r_right_out, r_left_out});
    assign m_axis_tuser  = r_clip;

endmodule

// ----- rtl/tgs_lfo.sv -----
module tgs_lfo #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [tgs_pkg::STEP_W-1:0]             i_phase_step,
    input  logic [tgs_pkg::DEPTH_W-1:0]            i_mod_depth,
    input  logic [tgs_pkg::GAIN_W-1:0]             i_gain,
    output logic                                   o_done,
    output logic signed [tgs_pkg::GF_W-1:0]        o_gain_factor
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
    // Keeps only the phase bits that select a table entry.
    localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - IDX_W)) - 32'd1);

    typedef enum logic [7:0] {
        L_IDLE  = 8'b0000_0001,
        L_SQ    = 8'b0000_0010,
        L_H1    = 8'b0000_0100,
        L_H2    = 8'b0000_1000,
        L_H3    = 8'b0001_0000,
        L_SIN   = 8'b0010_0000,
        L_DEPTH = 8'b0100_0000,
        L_GAIN  = 8'b1000_0000
    } t_lfo_state;

    t_lfo_state r_state, n_state;
    logic [31:0]                          r_phase;
    logic                                 r_done;
    logic [tgs_pkg::ARG_W-1:0]            r_x;
    logic [tgs_pkg::ARG_W-1:0]            r_x2;
    logic [tgs_pkg::POLY_W-1:0]           r_p;
    logic                                 r_neg;
    logic signed [15:0]                   r_s;
    logic signed [tgs_pkg::FACT_W-1:0]    r_fact;
    logic signed [tgs_pkg::GF_W-1:0]      r_gf;

    logic [31:0]                          phase_t;
    logic [15:0]                          quarter_r;
    logic [tgs_pkg::ARG_W-1:0]            x_init;
    logic [tgs_pkg::POLY_W-1:0]           mul_a;
    logic [tgs_pkg::ARG_W-1:0]            mul_b;
    logic [tgs_pkg::PROD_W-1:0]           mul_p;
    logic [tgs_pkg::ARG_W-1:0]            sine_mag;
    logic [14:0]                          sine_cap;
    logic signed [15:0]                   sine_val;
    logic signed [32:0]                   depth_prod;
    logic signed [tgs_pkg::FACT_W-1:0]    fact_val;
    logic signed [tgs_pkg::GF_W-1:0]      gf_val;

    // Turn fraction of the table entry, split into quadrant and Q16 offset.
    assign phase_t   = r_phase & PHASE_MASK;
    assign quarter_r = phase_t[29:14];
    assign x_init    = phase_t[30] ? (17'd65536 - {1'b0, quarter_r}) : {1'b0, quarter_r};

    // One shared multiplier evaluates the polynomial, one step per state.
    always_comb begin
        unique case (r_state)
            L_SQ: begin
                mul_a = tgs_pkg::POLY_W'(r_x);
                mul_b = r_x;
            end
            L_H1: begin
                mul_a = tgs_pkg::POLY_C7;
                mul_b = r_x2;
            end
            L_H2, L_H3: begin
                mul_a = r_p;
                mul_b = r_x2;
            end
            default: begin
                mul_a = r_p;
                mul_b = r_x;
            end
        endcase
    end

    assign mul_p = tgs_pkg::PROD_W'(mul_a) * tgs_pkg::PROD_W'(mul_b);

    // Final polynomial scale to Q15, capped, with the half-turn sign flip.
    assign sine_mag = mul_p[tgs_pkg::PROD_W-1:31];
    assign sine_cap = (sine_mag > 17'd32767) ? 15'h7fff : sine_mag[14:0];
    assign sine_val = r_neg ? -$signed({1'b0, sine_cap}) : $signed({1'b0, sine_cap});

    // Depth scaling with floor, then the gain product.
    assign depth_prod = r_s * $signed({1'b0, i_mod_depth});
    assign fact_val   = $signed(depth_prod[32:15]) + tgs_pkg::FACT_ONE;
    assign gf_val     = r_fact * $signed({1'b0, i_gain});

    // Step sequence.
    always_comb begin
        unique case (r_state)
            L_IDLE:  n_state = i_start ? L_SQ : L_IDLE;
            L_SQ:    n_state = L_H1;
            L_H1:    n_state = L_H2;
            L_H2:    n_state = L_H3;
            L_H3:    n_state = L_SIN;
            L_SIN:   n_state = L_DEPTH;
            L_DEPTH: n_state = L_GAIN;
            L_GAIN:  n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    // Control state and the phase accumulator, which advances once per frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_phase <= 32'd0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == L_GAIN);
            if (r_state == L_IDLE && i_start) begin
                r_phase <= r_phase + 32'(i_phase_step);
            end
        end
    end

    // Datapath registers, one multiplication result per step.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    r_x   <= x_init;
                    r_neg <= ~phase_t[31];
                end
            end
            L_SQ:    r_x2 <= mul_p[32:16];
            L_H1:    r_p  <= 31'({1'b0, tgs_pkg::POLY_C5} - mul_p[tgs_pkg::PROD_W-1:16]);
            L_H2:    r_p  <= 31'({1'b0, tgs_pkg::POLY_C3} - mul_p[tgs_pkg::PROD_W-1:16]);
            L_H3:    r_p  <= 31'({1'b0, tgs_pkg::POLY_C1} - mul_p[tgs_pkg::PROD_W-1:16]);
            L_SIN:   r_s    <= sine_val;
            L_DEPTH: r_fact <= fact_val;
            L_GAIN:  r_gf   <= gf_val;
            default: ;
        endcase
    end

    assign o_done        = r_done;
    assign o_gain_factor = r_gf;

endmodule

// ----- rtl/tgs_lane.sv -----
module tgs_lane #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  logic signed [tgs_pkg::GF_W-1:0]     i_gain_factor,
    output logic [SAMPLE_BITS-1:0]              o_sample,
    output logic                                o_clip
);

    localparam int PROD_W = SAMPLE_BITS + tgs_pkg::GF_W;
    localparam int Y_W    = PROD_W - tgs_pkg::OUT_SHIFT;

    logic signed [PROD_W-1:0] r_prod;
    logic [Y_W-1:0]           y;
    logic [Y_W-SAMPLE_BITS:0] y_top;
    logic                     ovf;

    // Sample times the combined modulation and gain factor.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= i_sample * i_gain_factor;
        end
    end

    // Floor shift, then saturate when the upper bits are not all sign.
    assign y     = r_prod[PROD_W-1:tgs_pkg::OUT_SHIFT];
    assign y_top = y[Y_W-1:SAMPLE_BITS-1];
    assign ovf   = !((&y_top) || !(|y_top));

    assign o_sample = !ovf ? y[SAMPLE_BITS-1:0] :
                      y[Y_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} :
                                 {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    assign o_clip   = ovf;

endmodule

// ----- rtl/tgs_checker.sv -----
module tgs_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   s_axis_tvalid,
    input logic                                   s_axis_tready,
    input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
    input logic                                   m_axis_tuser,
    input logic                                   i_cfg_we,
    input logic [tgs_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input logic [tgs_pkg::CFG_DATA_W-1:0]         i_cfg_wdata
);

    localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [SAMPLE_BITS-1:0] left_out;
    logic [SAMPLE_BITS-1:0] right_out;

    assign left_out  = m_axis_tdata[SAMPLE_BITS-1:0];
    assign right_out = m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // A stalled result keeps its data until the transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // Frames are processed one at a time: no input right after a transfer.
    a_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a frame is in flight");

    // A clipped frame has at least one channel at a rail.
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
        left_out == S_MAX || left_out == S_MIN ||
        right_out == S_MAX || right_out == S_MIN)
        else $error("clip flag without a saturated channel");

    // After reset no result is pending and the input side is open.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("bad state after reset");

endmodule

bind tremolo_gain_stage tgs_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tgs_checker (.*);

// ----- verif/tremolo_frame_checker.sv -----
// Watches the configuration port and both stream channels of the tremolo stage.
// It keeps its own copy of the registers and the LFO phase. It predicts every
// output frame and compares each output transfer with the oldest prediction.
module tremolo_frame_checker #(
    parameter int SAMPLE_BITS = 24,
    parameter int TABLE_BITS  = 10,
    parameter int DATA_W      = 48
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  logic                                    i_in_ready,
    input  logic [DATA_W-1:0]                       i_in_data,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_ready,
    input  logic [DATA_W-1:0]                       i_out_data,
    input  logic                                    i_out_clipped,
    input  logic                                    i_cfg_we,
    input  logic [tgs_pkg::CFG_ADDR_W-1:0]          i_cfg_addr,
    input  logic [tgs_pkg::CFG_DATA_W-1:0]          i_cfg_wdata,
    output int                                      o_fail_count,
    output int                                      o_frames_pending
);

    // Sine polynomial coefficients in Q30, odd terms only.
    localparam longint unsigned SINE_C1 = 64'd1686629713;
    localparam longint unsigned SINE_C3 = 64'd693598670;
    localparam longint unsigned SINE_C5 = 64'd85569278;
    localparam longint unsigned SINE_C7 = 64'd5026992;

    localparam longint OUT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic                          clipped;
    } t_stereo_result;

    t_stereo_result frames_due[$];

    logic [31:0]                    lfo_phase;
    logic [tgs_pkg::STEP_W-1:0]     phase_step;
    logic [tgs_pkg::DEPTH_W-1:0]    mod_depth;
    logic [tgs_pkg::GAIN_W-1:0]     gain_q;

    initial o_fail_count = 0;
    initial o_frames_pending = 0;

    // Table value for a phase: minus the sine at the start of the table slot,
    // built from a quarter-wave polynomial in Q16 and returned in Q1.15.
    function automatic longint lfo_tap(input logic [31:0] phase);
        logic [31:0]     turn;
        logic [1:0]      quad;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned p;
        longint unsigned mag;
        turn = (phase >> (32 - TABLE_BITS)) << (32 - TABLE_BITS);
        quad = turn[31:30];
        x = turn[29:14];
        if (quad[0]) begin
            x = 64'd65536 - x;
        end
        x2 = (x * x) >> 16;
        p = SINE_C7;
        p = SINE_C5 - ((p * x2) >> 16);
        p = SINE_C3 - ((p * x2) >> 16);
        p = SINE_C1 - ((p * x2) >> 16);
        mag = ((p * x) >> 16) >> 15;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        // The first half turn swings negative.
        return quad[1] ? longint'(mag) : -longint'(mag);
    endfunction

    // Expected output frame for one input frame at the current phase.
    function automatic t_stereo_result predict_frame(input logic [DATA_W-1:0] data);
        t_stereo_result                res;
        logic signed [SAMPLE_BITS-1:0] chan [2];
        longint                        factor;
        longint                        y;
        chan[0] = data[SAMPLE_BITS-1:0];
        chan[1] = data[2*SAMPLE_BITS-1:SAMPLE_BITS];
        factor = 64'sd32768 + ((lfo_tap(lfo_phase) * longint'(mod_depth)) >>> 15);
        res.clipped = 1'b0;
        for (int ch = 0; ch < 2; ch++) begin
            y = (longint'(chan[ch]) * factor * longint'(gain_q)) >>> 27;
            if (y > OUT_MAX) begin
                y = OUT_MAX;
                res.clipped = 1'b1;
            end else if (y < OUT_MIN) begin
                y = OUT_MIN;
                res.clipped = 1'b1;
            end
            if (ch == 0) begin
                res.left = SAMPLE_BITS'(y);
            end else begin
                res.right = SAMPLE_BITS'(y);
            end
        end
        return res;
    endfunction

    // Counts and prints a field mismatch.
    task automatic check_field(input string what, input longint want_v, input longint got_v);
        if (want_v != got_v) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, want_v, got_v);
        end
    endtask

    // Register writes, output comparison and prediction, all at the clock edge.
    always @(posedge i_clk) begin
        t_stereo_result want;
        if (!i_rst_n) begin
            lfo_phase  = 32'd0;
            phase_step = 23'd89478;
            mod_depth  = 16'd0;
            gain_q     = 16'd4096;
            frames_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    tgs_pkg::CFG_IDX_PHASE_STEP:
                        phase_step = i_cfg_wdata[tgs_pkg::STEP_W-1:0];
                    tgs_pkg::CFG_IDX_MOD_DEPTH:
                        mod_depth  = i_cfg_wdata[tgs_pkg::DEPTH_W-1:0];
                    tgs_pkg::CFG_IDX_GAIN:
                        gain_q     = i_cfg_wdata[tgs_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end

            // Output transfer: compare against the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (frames_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: output frame with none expected, expected none, actual %h",
                             $time, i_out_data);
                end else begin
                    want = frames_due.pop_front();
                    check_field("left_out", want.left,
                                $signed(i_out_data[SAMPLE_BITS-1:0]));
                    check_field("right_out", want.right,
                                $signed(i_out_data[2*SAMPLE_BITS-1:SAMPLE_BITS]));
                    check_field("clipped", want.clipped, i_out_clipped);
                end
            end

            // Input transfer: predict with the phase before the advance.
            if (i_in_valid && i_in_ready) begin
                frames_due.push_back(predict_frame(i_in_data));
                lfo_phase = lfo_phase + phase_step;
            end
        end
        o_frames_pending <= frames_due.size();
    end

endmodule

// ----- verif/tremolo_gain_stage_tb.sv -----
// Drives stereo frames and register settings into the tremolo stage, stalls
// both channels at random and reports the verdict from the checker.
module tremolo_gain_stage_tb;

    localparam int SAMPLE_BITS = 24;
    localparam int DATA_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    // Index past the last register; writes there must change nothing.
    localparam logic [tgs_pkg::CFG_ADDR_W-1:0] CFG_IDX_UNUSED = 2'd3;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [DATA_W-1:0]              s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [DATA_W-1:0]              m_axis_tdata;
    logic                           m_axis_tuser;
    logic                           i_cfg_we = 1'b0;
    logic [tgs_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [tgs_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    int fail_count;
    int frames_pending;
    int idle_pct = 12;

    tremolo_gain_stage dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    tremolo_frame_checker #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TABLE_BITS  (10),
        .DATA_W      (DATA_W)
    ) checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (s_axis_tvalid),
        .i_in_ready       (s_axis_tready),
        .i_in_data        (s_axis_tdata),
        .i_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .i_out_data       (m_axis_tdata),
        .i_out_clipped    (m_axis_tuser),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_fail_count     (fail_count),
        .o_frames_pending (frames_pending)
    );

    // Clock with a period of two time units.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the stage hangs.
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // Output side stalls at random.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Mostly full-range samples, with extremes and small values mixed in.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(19))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3:       return -24'sd1;
            4, 5:    return SAMPLE_BITS'($signed($urandom_range(511)) - 256);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // One frame transfer, after a random gap. Leaves tvalid high on return.
    task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] left,
                              input logic signed [SAMPLE_BITS-1:0] right);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stops sending and waits until every expected frame has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (frames_pending != 0);
    endtask

    task automatic write_reg(input logic [tgs_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [tgs_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    // Writes all three registers, optionally pokes the unused index.
    task automatic load_regs(input logic [tgs_pkg::STEP_W-1:0]  step,
                             input logic [tgs_pkg::DEPTH_W-1:0] depth,
                             input logic [tgs_pkg::GAIN_W-1:0]  gain_v,
                             input bit                          poke_unused);
        write_reg(tgs_pkg::CFG_IDX_PHASE_STEP, step);
        write_reg(tgs_pkg::CFG_IDX_MOD_DEPTH, tgs_pkg::CFG_DATA_W'(depth));
        write_reg(tgs_pkg::CFG_IDX_GAIN, tgs_pkg::CFG_DATA_W'(gain_v));
        if (poke_unused) begin
            write_reg(CFG_IDX_UNUSED, tgs_pkg::CFG_DATA_W'($urandom));
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [tgs_pkg::STEP_W-1:0]  step;
        logic [tgs_pkg::DEPTH_W-1:0] depth;
        logic [tgs_pkg::GAIN_W-1:0]  gain_v;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: no modulation and unity gain, so samples pass through.
        send_frame('0, '0);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_frame(-24'sd1, 24'sd1);
        drain();

        // Fastest LFO, full depth and maximum gain: heavy clipping.
        load_regs(23'h7FFFFF, 16'd32768, 16'hFFFF, 1'b1);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_frame(24'sd1, -24'sd1);
        send_frame(24'sd12345, '0);
        send_frame('0, SAMPLE_MAX);
        send_frame(24'sd300, -24'sd700);
        drain();

        // Depth above full with the phase frozen: the factor may invert samples.
        load_regs('0, 16'hFFFF, 16'd4096, 1'b0);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(24'sd4000000, -24'sd4000000);
        send_frame(-24'sd1, 24'sd1);
        send_frame(24'sd77, SAMPLE_MAX);
        drain();

        // Zero gain and zero depth with the smallest step.
        load_regs(23'd1, '0, '0, 1'b1);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, -24'sd1);
        send_frame(24'sd5, 24'sd9);
        drain();

        // Random settings per phase; one phase runs without any stalls.
        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(9))
                0:       step = '0;
                1, 2:    step = 23'h7FFFFF;
                3:       step = tgs_pkg::STEP_W'($urandom_range(4095));
                default: step = tgs_pkg::STEP_W'($urandom_range(23'h7FFFFF, 23'h100000));
            endcase
            case ($urandom_range(9))
                0:       depth = '0;
                1, 2:    depth = 16'd32768;
                3, 4:    depth = tgs_pkg::DEPTH_W'($urandom_range(65535, 32769));
                default: depth = tgs_pkg::DEPTH_W'($urandom_range(32768));
            endcase
            case ($urandom_range(9))
                0:       gain_v = '0;
                1:       gain_v = 16'hFFFF;
                2, 3:    gain_v = 16'd4096;
                default: gain_v = tgs_pkg::GAIN_W'($urandom_range(12288));
            endcase
            load_regs(step, depth, gain_v, 1'($urandom_range(1)));
            idle_pct = (ph == 4) ? 0 : 12;
            repeat (150) send_frame(pick_sample(), pick_sample());
            drain();
        end

        // Let any stray output show up before the verdict.
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
